// File: design/ortt_pkg.sv
package ortt_pkg;

  localparam int NODES_DEF        = 8;
  localparam int PENDING_DEF      = 8;
  localparam int BUFFER_BYTES_DEF = 512;

  localparam logic [2:0] ACT_UPDATE  = 3'd0;
  localparam logic [2:0] ACT_RESET   = 3'd1;
  localparam logic [2:0] ACT_RESERVE = 3'd2;
  localparam logic [2:0] ACT_SINGLE  = 3'd3;
  localparam logic [2:0] ACT_PART    = 3'd4;
  localparam logic [2:0] ACT_COLLECT = 3'd5;
  localparam logic [2:0] ACT_RELEASE = 3'd6;
  localparam logic [2:0] ACT_UNDEF   = 3'd7;

  localparam logic [3:0] ST_OK        = 4'd0;
  localparam logic [3:0] ST_NO_ROUTE  = 4'd1;
  localparam logic [3:0] ST_STALE     = 4'd2;
  localparam logic [3:0] ST_FULL      = 4'd3;
  localparam logic [3:0] ST_INVALID   = 4'd4;
  localparam logic [3:0] ST_SEQUENCE  = 4'd5;
  localparam logic [3:0] ST_TOO_LARGE = 4'd6;
  localparam logic [3:0] ST_UNMATCHED = 4'd7;
  localparam logic [3:0] ST_NOT_READY = 4'd8;
  localparam logic [3:0] ST_EMPTY     = 4'd9;

  localparam logic [7:0] ADDR_BCAST = 8'hFF;

  typedef struct packed {
    logic [2:0]  action;
    logic [7:0]  addr;
    logic [31:0] boot_id;
    logic [7:0]  msg_type;
    logic        streaming;
    logic [15:0] resp_tag;
    logic [9:0]  body_len;
    logic        final_req;
    logic [15:0] part_or_status;
    logic [2:0]  slot;
  } in_item_t;

  typedef struct packed {
    logic [3:0]  status;
    logic [2:0]  slot_out;
    logic [15:0] tag_given;
    logic        matched;
    logic        done_res;
    logic [9:0]  resp_len;
    logic [15:0] remote_code;
    logic [15:0] parts;
    logic [3:0]  cancelled;
  } out_item_t;

  typedef struct packed {
    logic capture;
    logic exec;
    logic probe;
  } ctl_cmd_t;

  typedef struct packed {
    logic need_probe;
    logic probe_end;
  } ctl_sts_t;

  function automatic logic [15:0] next_tag(input logic [15:0] t);
    logic [15:0] n;
    n = t + 16'd1;
    if (n == 16'd0) begin
      n = 16'd1;
    end
    return n;
  endfunction

endpackage

// File: design/ortt_ctrl.sv
module ortt_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  output logic              out_valid,
  input  logic              out_stall,
  input  ortt_pkg::ctl_sts_t sts,
  output ortt_pkg::ctl_cmd_t cmd
);
  import ortt_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_EXEC  = 4'b0010,
    S_PROBE = 4'b0100,
    S_RESP  = 4'b1000
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt   = state_r;
    cmd         = '0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd.exec  = 1'b1;
        state_nxt = sts.need_probe ? S_PROBE : S_RESP;
      end
      S_PROBE: begin
        cmd.probe = 1'b1;
        if (sts.probe_end) begin
          state_nxt = S_RESP;
        end
      end
      S_RESP: begin
        if (!out_stall) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = (state_r == S_RESP);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// File: design/ortt_dp.sv
module ortt_dp #(
  parameter int NODES        = ortt_pkg::NODES_DEF,
  parameter int PENDING      = ortt_pkg::PENDING_DEF,
  parameter int BUFFER_BYTES = ortt_pkg::BUFFER_BYTES_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  ortt_pkg::in_item_t  in_item,
  input  ortt_pkg::ctl_cmd_t  cmd,
  output ortt_pkg::ctl_sts_t  sts,
  output ortt_pkg::out_item_t out_item
);
  import ortt_pkg::*;

  localparam int NW = (NODES > 1) ? $clog2(NODES) : 1;
  localparam int PW = (PENDING > 1) ? $clog2(PENDING) : 1;
  localparam int KW = $clog2(PENDING + 2);
  localparam int CW = $clog2(PENDING + 1) + 1;
  localparam logic [16:0] BUF_LIM = 17'(BUFFER_BYTES);

  in_item_t  req_r;
  out_item_t res_r;
  out_item_t res_nxt;

  logic        node_valid_r [NODES];
  logic [7:0]  node_addr_r  [NODES];
  logic [31:0] node_boot_r  [NODES];

  logic          ent_valid_r  [PENDING];
  logic          ent_done_r   [PENDING];
  logic          ent_stream_r [PENDING];
  logic [7:0]    ent_type_r   [PENDING];
  logic [7:0]    ent_src_r    [PENDING];
  logic [NW-1:0] ent_node_r   [PENDING];
  logic [15:0]   ent_tag_r    [PENDING];
  logic [31:0]   ent_boot_r   [PENDING];
  logic [9:0]    ent_len_r    [PENDING];
  logic [15:0]   ent_parts_r  [PENDING];
  logic [15:0]   ent_remote_r [PENDING];
  logic [3:0]    ent_result_r [PENDING];

  logic [15:0]   last_tag_r;
  logic [15:0]   cand_r;
  logic [KW-1:0] probe_cnt_r;
  logic [PW-1:0] fslot_r;
  logic [NW-1:0] nidx_r;

  logic          node_hit, node_free;
  logic [NW-1:0] node_idx, node_free_idx;
  logic          slot_free;
  logic [PW-1:0] slot_free_idx;
  logic          dmatch;
  logic [PW-1:0] midx;
  logic [PENDING-1:0] cancel_vec;
  logic [CW-1:0] cancel_cnt;
  logic          tag_used;
  logic          is_upd, want_stream, deliv_bad, upd_bad, slot_ok;
  logic [PW-1:0] sl;
  logic          m_stale;
  logic [16:0]   len_sum;

  always_comb begin
    node_hit      = 1'b0;
    node_idx      = '0;
    node_free     = 1'b0;
    node_free_idx = '0;
    for (int i = NODES - 1; i >= 0; i--) begin
      if (node_valid_r[i] && node_addr_r[i] == req_r.addr) begin
        node_hit = 1'b1;
        node_idx = NW'(i);
      end
      if (!node_valid_r[i]) begin
        node_free     = 1'b1;
        node_free_idx = NW'(i);
      end
    end
  end

  always_comb begin
    want_stream   = (req_r.action == ACT_PART);
    slot_free     = 1'b0;
    slot_free_idx = '0;
    dmatch        = 1'b0;
    midx          = '0;
    cancel_cnt    = '0;
    tag_used      = 1'b0;
    for (int i = PENDING - 1; i >= 0; i--) begin
      if (!ent_valid_r[i]) begin
        slot_free     = 1'b1;
        slot_free_idx = PW'(i);
      end
      if (ent_valid_r[i] && !ent_done_r[i] && ent_stream_r[i] == want_stream &&
          ent_type_r[i] == req_r.msg_type && ent_src_r[i] == req_r.addr &&
          ent_tag_r[i] == req_r.resp_tag) begin
        dmatch = 1'b1;
        midx   = PW'(i);
      end
      cancel_vec[i] = ent_valid_r[i] && !ent_done_r[i] && ent_node_r[i] == node_idx;
      if (ent_valid_r[i] && ent_tag_r[i] == cand_r) begin
        tag_used = 1'b1;
      end
    end
    for (int i = 0; i < PENDING; i++) begin
      cancel_cnt = cancel_cnt + CW'(cancel_vec[i]);
    end
  end

  always_comb begin
    is_upd    = (req_r.action == ACT_UPDATE);
    upd_bad   = is_upd && (req_r.addr == 8'd0 || req_r.addr == ADDR_BCAST);
    deliv_bad = (req_r.msg_type == 8'd0) || (req_r.resp_tag == 16'd0) ||
                (17'(req_r.body_len) > BUF_LIM) ||
                (req_r.action == ACT_SINGLE && req_r.body_len == 10'd0);
    slot_ok   = (32'(req_r.slot) < 32'(PENDING));
    sl        = PW'(req_r.slot);
    m_stale   = node_boot_r[ent_node_r[midx]] != ent_boot_r[midx];
    len_sum   = 17'(ent_len_r[midx]) + 17'(req_r.body_len);
  end

  assign sts.need_probe = (req_r.action == ACT_RESERVE) && (req_r.msg_type != 8'd0) &&
                          node_hit && (node_boot_r[node_idx] == req_r.boot_id) &&
                          slot_free;
  assign sts.probe_end  = !tag_used || (probe_cnt_r == KW'(PENDING));
  assign out_item       = res_r;

  always_comb begin
    res_nxt = res_r;
    if (cmd.exec) begin
      res_nxt        = '0;
      res_nxt.status = ST_INVALID;
      case (req_r.action)
        ACT_UPDATE, ACT_RESET: begin
          if (upd_bad) begin
            res_nxt.status = ST_NO_ROUTE;
          end else if (!node_hit) begin
            if (!is_upd) begin
              res_nxt.status = ST_NO_ROUTE;
            end else if (!node_free) begin
              res_nxt.status = ST_FULL;
            end else begin
              res_nxt.status = ST_OK;
            end
          end else if (is_upd && node_boot_r[node_idx] == req_r.boot_id) begin
            res_nxt.status = ST_OK;
          end else begin
            res_nxt.cancelled = 4'(cancel_cnt);
            res_nxt.status    = ST_OK;
          end
        end
        ACT_RESERVE: begin
          if (req_r.msg_type == 8'd0) begin
            res_nxt.status = ST_INVALID;
          end else if (!node_hit) begin
            res_nxt.status = ST_NO_ROUTE;
          end else if (node_boot_r[node_idx] != req_r.boot_id) begin
            res_nxt.status = ST_STALE;
          end else begin
            res_nxt.status = ST_FULL;
          end
        end
        ACT_SINGLE, ACT_PART: begin
          if (deliv_bad) begin
            res_nxt.status = ST_INVALID;
          end else if (!dmatch) begin
            res_nxt.status = ST_UNMATCHED;
          end else begin
            res_nxt.slot_out = 3'(midx);
            res_nxt.matched  = 1'b1;
            res_nxt.done_res = 1'b1;
            if (m_stale) begin
              res_nxt.status = ST_STALE;
            end else if (!want_stream) begin
              res_nxt.status = ST_OK;
            end else if (!req_r.final_req && req_r.part_or_status != ent_parts_r[midx]) begin
              res_nxt.status = ST_SEQUENCE;
            end else if (len_sum > BUF_LIM) begin
              res_nxt.status = ST_TOO_LARGE;
            end else begin
              res_nxt.status = ST_OK;
              if (!req_r.final_req) begin
                res_nxt.done_res = 1'b0;
              end
            end
          end
        end
        ACT_COLLECT, ACT_RELEASE: begin
          if (!slot_ok) begin
            res_nxt.status = ST_INVALID;
          end else begin
            res_nxt.slot_out = req_r.slot;
            if (!ent_valid_r[sl]) begin
              res_nxt.status = ST_EMPTY;
            end else if (req_r.action == ACT_RELEASE) begin
              res_nxt.status = ST_OK;
            end else if (!ent_done_r[sl]) begin
              res_nxt.status = ST_NOT_READY;
            end else begin
              res_nxt.status = ent_result_r[sl];
              if (ent_result_r[sl] == ST_OK) begin
                res_nxt.resp_len    = ent_len_r[sl];
                res_nxt.remote_code = ent_remote_r[sl];
                res_nxt.parts       = ent_parts_r[sl];
              end
            end
          end
        end
        default: res_nxt.status = ST_INVALID;
      endcase
    end else if (cmd.probe && !tag_used) begin
      res_nxt.status    = ST_OK;
      res_nxt.slot_out  = 3'(fslot_r);
      res_nxt.tag_given = cand_r;
    end
  end

  always_ff @(posedge clk) begin
    res_r <= res_nxt;
    if (cmd.capture) begin
      req_r <= in_item;
    end
    if (cmd.exec) begin
      case (req_r.action)
        ACT_UPDATE, ACT_RESET: begin
          if (!upd_bad && !node_hit && is_upd && node_free) begin
            node_addr_r[node_free_idx] <= req_r.addr;
            node_boot_r[node_free_idx] <= req_r.boot_id;
          end else if (!upd_bad && node_hit &&
                       !(is_upd && node_boot_r[node_idx] == req_r.boot_id)) begin
            for (int i = 0; i < PENDING; i++) begin
              if (cancel_vec[i]) begin
                ent_result_r[i] <= ST_STALE;
              end
            end
            if (is_upd) begin
              node_boot_r[node_idx] <= req_r.boot_id;
            end
          end
        end
        ACT_RESERVE: begin
          cand_r  <= next_tag(last_tag_r);
          fslot_r <= slot_free_idx;
          nidx_r  <= node_idx;
        end
        ACT_SINGLE, ACT_PART: begin
          if (!deliv_bad && dmatch) begin
            if (m_stale) begin
              ent_result_r[midx] <= ST_STALE;
            end else if (!want_stream) begin
              ent_len_r[midx]    <= req_r.body_len;
              ent_result_r[midx] <= ST_OK;
            end else if (!req_r.final_req && req_r.part_or_status != ent_parts_r[midx]) begin
              ent_result_r[midx] <= ST_SEQUENCE;
            end else if (len_sum > BUF_LIM) begin
              ent_result_r[midx] <= ST_TOO_LARGE;
            end else begin
              ent_len_r[midx] <= 10'(len_sum);
              if (!req_r.final_req) begin
                ent_parts_r[midx] <= ent_parts_r[midx] + 16'd1;
              end else begin
                ent_remote_r[midx] <= req_r.part_or_status;
                ent_result_r[midx] <= ST_OK;
              end
            end
          end
        end
        default: begin
        end
      endcase
    end
    if (cmd.probe) begin
      if (!tag_used) begin
        ent_stream_r[fslot_r] <= req_r.streaming;
        ent_type_r[fslot_r]   <= req_r.msg_type;
        ent_src_r[fslot_r]    <= req_r.addr;
        ent_node_r[fslot_r]   <= nidx_r;
        ent_tag_r[fslot_r]    <= cand_r;
        ent_boot_r[fslot_r]   <= node_boot_r[nidx_r];
        ent_len_r[fslot_r]    <= '0;
        ent_parts_r[fslot_r]  <= '0;
        ent_remote_r[fslot_r] <= '0;
        ent_result_r[fslot_r] <= ST_OK;
      end else begin
        cand_r <= next_tag(cand_r);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_tag_r  <= '0;
      probe_cnt_r <= '0;
      for (int i = 0; i < NODES; i++) begin
        node_valid_r[i] <= 1'b0;
      end
      for (int i = 0; i < PENDING; i++) begin
        ent_valid_r[i] <= 1'b0;
        ent_done_r[i]  <= 1'b0;
      end
    end else begin
      if (cmd.exec) begin
        probe_cnt_r <= '0;
        case (req_r.action)
          ACT_UPDATE: begin
            if (!upd_bad && !node_hit && node_free) begin
              node_valid_r[node_free_idx] <= 1'b1;
            end
            if (!upd_bad && node_hit && node_boot_r[node_idx] != req_r.boot_id) begin
              for (int i = 0; i < PENDING; i++) begin
                if (cancel_vec[i]) begin
                  ent_done_r[i] <= 1'b1;
                end
              end
            end
          end
          ACT_RESET: begin
            if (node_hit) begin
              for (int i = 0; i < PENDING; i++) begin
                if (cancel_vec[i]) begin
                  ent_done_r[i] <= 1'b1;
                end
              end
            end
          end
          ACT_SINGLE, ACT_PART: begin
            if (!deliv_bad && dmatch) begin
              if (m_stale || !want_stream || req_r.final_req ||
                  req_r.part_or_status != ent_parts_r[midx] || len_sum > BUF_LIM) begin
                ent_done_r[midx] <= 1'b1;
              end
            end
          end
          ACT_COLLECT, ACT_RELEASE: begin
            if (slot_ok && ent_valid_r[sl] &&
                (req_r.action == ACT_RELEASE || ent_done_r[sl])) begin
              ent_valid_r[sl] <= 1'b0;
              ent_done_r[sl]  <= 1'b0;
            end
          end
          default: begin
          end
        endcase
      end
      if (cmd.probe) begin
        if (!tag_used) begin
          ent_valid_r[fslot_r] <= 1'b1;
          ent_done_r[fslot_r]  <= 1'b0;
          last_tag_r           <= cand_r;
        end else begin
          probe_cnt_r <= probe_cnt_r + KW'(1);
        end
      end
    end
  end

endmodule

// File: design/outstanding_request_tag_tracker.sv
// Outstanding request tag tracker with a node table and a pending request table.
// One request enters on the in_ channel (in_valid, in_stall, in_item) and gives
// exactly one result on the out_ channel (out_valid, out_stall, out_item).
// The block takes one request at a time: in_stall is high from the cycle after
// acceptance until the result has been taken.
// A request is captured on acceptance, executed in the EXEC state, and its result
// is registered and shown in the RESP state. A valid reserve with a current node
// and a free slot first probes in the PROBE state, one candidate tag per cycle
// against all pending tags, up to PENDING + 1 candidates.
// Even with a receiver that never stalls, a new request is taken only after the
// result of the last one has been taken.
// While out_stall is high the result is held stable and no request is taken.
// A synchronous reset (rst_n low) clears all node and pending valid bits and
// the last issued tag; the block is ready the first cycle after reset.
module outstanding_request_tag_tracker #(
  parameter int NODES        = ortt_pkg::NODES_DEF,
  parameter int PENDING      = ortt_pkg::PENDING_DEF,
  parameter int BUFFER_BYTES = ortt_pkg::BUFFER_BYTES_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  ortt_pkg::in_item_t  in_item,
  output logic                out_valid,
  input  logic                out_stall,
  output ortt_pkg::out_item_t out_item
);
  import ortt_pkg::*;

  ctl_cmd_t cmd;
  ctl_sts_t sts;

  ortt_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  ortt_dp #(
    .NODES        (NODES),
    .PENDING      (PENDING),
    .BUFFER_BYTES (BUFFER_BYTES)
  ) u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_item  (in_item),
    .cmd      (cmd),
    .sts      (sts),
    .out_item (out_item)
  );

endmodule

// File: design/ortt_checker.sv
module ortt_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_stall,
  input logic                out_valid,
  input logic                out_stall,
  input ortt_pkg::out_item_t out_item
);
  import ortt_pkg::*;

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_item))
    else $error("stalled result changed");

  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall && !out_valid)
    else $error("request taken while another is in flight");

  a_tag: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_item.tag_given != 16'd0 |-> out_item.status == ST_OK)
    else $error("tag given with a failing status");

  a_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_item.matched |-> !out_item.done_res)
    else $error("completion without a match");

endmodule

bind outstanding_request_tag_tracker ortt_checker u_ortt_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_item  (out_item)
);

// File: tb/tb_outstanding_request_tag_tracker.sv
`timescale 1ns / 1ps

module tb_outstanding_request_tag_tracker;
  import ortt_pkg::*;

  localparam int NNODE = NODES_DEF;
  localparam int NPEND = PENDING_DEF;
  localparam int BUFB = BUFFER_BYTES_DEF;
  localparam int WATCHDOG = 20000;

  class tag_tracker_scoreboard;
    bit        nd_valid[NNODE];
    bit [7:0]  nd_addr[NNODE];
    bit [31:0] nd_boot[NNODE];
    bit        e_valid[NPEND];
    bit        e_done[NPEND];
    bit        e_stream[NPEND];
    bit [7:0]  e_type[NPEND];
    bit [7:0]  e_src[NPEND];
    bit [2:0]  e_node[NPEND];
    bit [15:0] e_tag[NPEND];
    bit [31:0] e_boot[NPEND];
    bit [9:0]  e_len[NPEND];
    bit [15:0] e_parts[NPEND];
    bit [15:0] e_remote[NPEND];
    bit [3:0]  e_res[NPEND];
    bit [15:0] issued_tag;
    out_item_t pending_results[$];
    int errors;

    function void clear_entry(int i);
      e_valid[i] = 0; e_done[i] = 0; e_stream[i] = 0; e_type[i] = 0; e_src[i] = 0;
      e_node[i] = 0; e_tag[i] = 0; e_boot[i] = 0; e_len[i] = 0; e_parts[i] = 0;
      e_remote[i] = 0; e_res[i] = 0;
    endfunction

    function void init();
      for (int i = 0; i < NNODE; i++) begin
        nd_valid[i] = 0; nd_addr[i] = 0; nd_boot[i] = 0;
      end
      for (int i = 0; i < NPEND; i++) clear_entry(i);
      issued_tag = 0;
      errors = 0;
    endfunction

    function int lookup_node(bit [7:0] a);
      for (int i = 0; i < NNODE; i++) if (nd_valid[i] && nd_addr[i] == a) return i;
      return -1;
    endfunction

    function bit tag_busy(bit [15:0] t);
      for (int i = 0; i < NPEND; i++) if (e_valid[i] && e_tag[i] == t) return 1;
      return 0;
    endfunction

    function void note_request(in_item_t q);
      out_item_t r;
      int n, i, k;
      bit got;
      bit [15:0] t;
      bit want;
      r = '0;
      r.status = ST_INVALID;
      case (q.action)
        ACT_UPDATE, ACT_RESET: begin
          if (q.action == ACT_UPDATE && (q.addr == 8'd0 || q.addr == ADDR_BCAST)) begin
            r.status = ST_NO_ROUTE;
          end else begin
            n = lookup_node(q.addr);
            if (n < 0) begin
              if (q.action == ACT_RESET) begin
                r.status = ST_NO_ROUTE;
              end else begin
                for (i = 0; i < NNODE && nd_valid[i]; i++) ;
                if (i == NNODE) begin
                  r.status = ST_FULL;
                end else begin
                  nd_valid[i] = 1; nd_addr[i] = q.addr; nd_boot[i] = q.boot_id;
                  r.status = ST_OK;
                end
              end
            end else if (q.action == ACT_UPDATE && nd_boot[n] == q.boot_id) begin
              r.status = ST_OK;
            end else begin
              for (i = 0; i < NPEND; i++) begin
                if (e_valid[i] && !e_done[i] && e_node[i] == n) begin
                  e_res[i] = ST_STALE; e_done[i] = 1; r.cancelled++;
                end
              end
              if (q.action == ACT_UPDATE) nd_boot[n] = q.boot_id;
              r.status = ST_OK;
            end
          end
        end
        ACT_RESERVE: begin
          n = lookup_node(q.addr);
          if (q.msg_type == 0) begin
            r.status = ST_INVALID;
          end else if (n < 0) begin
            r.status = ST_NO_ROUTE;
          end else if (nd_boot[n] != q.boot_id) begin
            r.status = ST_STALE;
          end else begin
            for (i = 0; i < NPEND && e_valid[i]; i++) ;
            r.status = ST_FULL;
            if (i < NPEND) begin
              t = issued_tag;
              got = 0;
              for (k = 0; k <= NPEND && !got; k++) begin
                t = t + 16'd1;
                if (t == 0) t = 1;
                got = !tag_busy(t);
              end
              if (got) begin
                issued_tag = t;
                clear_entry(i);
                e_valid[i] = 1; e_stream[i] = q.streaming; e_type[i] = q.msg_type;
                e_src[i] = q.addr; e_node[i] = n[2:0]; e_tag[i] = t; e_boot[i] = nd_boot[n];
                r.status = ST_OK; r.slot_out = i[2:0]; r.tag_given = t;
              end
            end
          end
        end
        ACT_SINGLE, ACT_PART: begin
          want = (q.action == ACT_PART);
          if (q.msg_type == 0 || q.resp_tag == 0 || q.body_len > BUFB ||
              (q.action == ACT_SINGLE && q.body_len == 0)) begin
            r.status = ST_INVALID;
          end else begin
            r.status = ST_UNMATCHED;
            for (i = 0; i < NPEND; i++) begin
              if (!e_valid[i] || e_done[i] || e_stream[i] != want || e_type[i] != q.msg_type
                  || e_src[i] != q.addr || e_tag[i] != q.resp_tag) continue;
              r.slot_out = i[2:0];
              r.matched = 1;
              if (nd_boot[e_node[i]] != e_boot[i]) begin
                e_res[i] = ST_STALE; e_done[i] = 1;
              end else if (q.action == ACT_SINGLE) begin
                e_len[i] = q.body_len; e_res[i] = ST_OK; e_done[i] = 1;
              end else if (!q.final_req && q.part_or_status != e_parts[i]) begin
                e_res[i] = ST_SEQUENCE; e_done[i] = 1;
              end else if (int'(e_len[i]) + int'(q.body_len) > BUFB) begin
                e_res[i] = ST_TOO_LARGE; e_done[i] = 1;
              end else begin
                e_len[i] = e_len[i] + q.body_len;
                if (!q.final_req) begin
                  e_parts[i] = e_parts[i] + 16'd1;
                end else begin
                  e_remote[i] = q.part_or_status; e_res[i] = ST_OK; e_done[i] = 1;
                end
              end
              r.done_res = e_done[i];
              r.status = e_done[i] ? e_res[i] : ST_OK;
              break;
            end
          end
        end
        ACT_COLLECT, ACT_RELEASE: begin
          i = int'(q.slot);
          r.slot_out = q.slot;
          if (!e_valid[i]) begin
            r.status = ST_EMPTY;
          end else if (q.action == ACT_RELEASE) begin
            clear_entry(i); r.status = ST_OK;
          end else if (!e_done[i]) begin
            r.status = ST_NOT_READY;
          end else begin
            r.status = e_res[i];
            if (r.status == ST_OK) begin
              r.resp_len = e_len[i]; r.remote_code = e_remote[i]; r.parts = e_parts[i];
            end
            clear_entry(i);
          end
        end
        default: r.status = ST_INVALID;
      endcase
      pending_results.push_back(r);
    endfunction

    function void check_result(out_item_t got);
      out_item_t exp;
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result %h", $time, got);
        errors++;
        return;
      end
      exp = pending_results.pop_front();
      if (got !== exp) begin
        $display("%0t: mismatch expected %h actual %h", $time, exp, got);
        if (got.status !== exp.status)
          $display("%0t:  status expected %0d actual %0d", $time, exp.status, got.status);
        if (got.slot_out !== exp.slot_out)
          $display("%0t:  slot expected %0d actual %0d", $time, exp.slot_out, got.slot_out);
        if (got.tag_given !== exp.tag_given)
          $display("%0t:  tag expected %0d actual %0d", $time, exp.tag_given, got.tag_given);
        if (got.cancelled !== exp.cancelled)
          $display("%0t:  cancelled expected %0d actual %0d", $time, exp.cancelled,
                   got.cancelled);
        errors++;
      end
    endfunction
  endclass

  logic clk = 0;
  logic rst_n = 0;
  logic in_valid = 0;
  logic in_stall;
  in_item_t in_item = '0;
  logic out_valid;
  logic out_stall = 0;
  out_item_t out_item;

  tag_tracker_scoreboard sb;
  int send_idle_pct = 31;
  int recv_idle_pct = 81;
  int quiet_cycles = 0;
  bit [7:0] known_addr[4] = '{8'd1, 8'd2, 8'd77, 8'd254};
  bit [31:0] known_boot[4];
  bit [15:0] live_tag[NPEND];
  bit [7:0] live_type[NPEND];
  bit [7:0] live_src[NPEND];
  bit live_strm[NPEND];
  bit [15:0] live_part[NPEND];

  outstanding_request_tag_tracker dut (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
    .in_item(in_item), .out_valid(out_valid), .out_stall(out_stall), .out_item(out_item)
  );

  always begin
    #6 clk = 1;
    #6 clk = 0;
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        sb.note_request(in_item);
        if (in_item.action == ACT_RESERVE && sb.pending_results[$].status == ST_OK) begin
          live_tag[sb.pending_results[$].slot_out] <= sb.pending_results[$].tag_given;
          live_type[sb.pending_results[$].slot_out] <= in_item.msg_type;
          live_src[sb.pending_results[$].slot_out] <= in_item.addr;
          live_strm[sb.pending_results[$].slot_out] <= in_item.streaming;
          live_part[sb.pending_results[$].slot_out] <= 0;
        end
        if (in_item.action == ACT_PART && sb.pending_results[$].matched &&
            !sb.pending_results[$].done_res)
          live_part[sb.pending_results[$].slot_out] <=
            live_part[sb.pending_results[$].slot_out] + 16'd1;
      end
      if (out_valid && !out_stall) sb.check_result(out_item);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      out_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (quiet_cycles >= WATCHDOG) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  task automatic send_request(in_item_t q);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 0;
      @(posedge clk);
    end
    in_item <= q;
    in_valid <= 1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  function automatic in_item_t noise_item();
    in_item_t q;
    logic [127:0] raw;
    raw = {$urandom, $urandom, $urandom, $urandom};
    q = raw[$bits(in_item_t)-1:0];
    return q;
  endfunction

  function automatic in_item_t shaped_item();
    in_item_t q;
    int k, s;
    q = noise_item();
    k = $urandom_range(3);
    s = $urandom_range(NPEND - 1);
    q.addr = known_addr[k];
    case ($urandom_range(19))
      0: begin
        q.action = ACT_UPDATE;
        q.boot_id = ($urandom_range(3) == 0) ? $urandom : known_boot[k];
        known_boot[k] = q.boot_id;
      end
      1: q.action = ACT_RESET;
      2, 3, 4, 5: begin
        q.action = ACT_RESERVE;
        q.boot_id = known_boot[k];
        if (q.msg_type == 0) q.msg_type = 1;
      end
      6, 7, 8, 9, 10, 11: begin
        q.action = live_strm[s] ? ACT_PART : ACT_SINGLE;
        q.addr = live_src[s];
        q.msg_type = live_type[s];
        q.resp_tag = live_tag[s];
        q.body_len = 10'($urandom_range(1, 120));
        q.final_req = ($urandom_range(3) == 0);
        if (!q.final_req && $urandom_range(9) != 0) q.part_or_status = live_part[s];
      end
      12, 13, 14: begin q.action = ACT_COLLECT; q.slot = 3'(s); end
      15: begin q.action = ACT_RELEASE; q.slot = 3'(s); end
      default: ;
    endcase
    return q;
  endfunction

  task automatic track(in_item_t q);
    send_request(q);
  endtask

  initial begin
    in_item_t q;
    sb = new();
    sb.init();
    for (int i = 0; i < 4; i++) known_boot[i] = $urandom;
    for (int i = 0; i < NPEND; i++) begin
      live_tag[i] = 0; live_type[i] = 0; live_src[i] = 0; live_strm[i] = 0; live_part[i] = 0;
    end
    repeat (11) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    q = '0; q.action = ACT_UPDATE; q.addr = 8'd0; track(q);
    q.addr = ADDR_BCAST; track(q);
    q.action = ACT_RESET; q.addr = 8'd9; track(q);
    for (int i = 0; i < 4; i++) begin
      q = '0; q.action = ACT_UPDATE; q.addr = known_addr[i]; q.boot_id = known_boot[i];
      track(q);
    end
    q = '0; q.action = ACT_RESERVE; q.addr = 8'd1; q.boot_id = known_boot[0]; track(q);
    q.msg_type = 8'hFF; q.boot_id = ~known_boot[0]; track(q);
    q.addr = 8'd99; track(q);
    q.boot_id = known_boot[0]; q.addr = 8'd1;
    for (int i = 0; i < NPEND + 1; i++) begin q.streaming = i[0]; track(q); end
    q = '0; q.action = ACT_SINGLE; q.addr = 8'd1; q.msg_type = 8'hFF; q.resp_tag = 16'd1;
    track(q);
    q.body_len = 10'd513; track(q);
    q.body_len = 10'd512; q.resp_tag = 16'hFFFF; track(q);
    q.resp_tag = 16'd1; track(q);
    q.action = ACT_PART; q.resp_tag = 16'd2; q.part_or_status = 16'd5; track(q);
    q = '0; q.action = ACT_COLLECT; q.slot = 3'd0; track(q);
    q.slot = 3'd1; track(q);
    q.slot = 3'd7; track(q);
    q.action = ACT_RESET; q.addr = 8'd1; track(q);
    q.action = ACT_UNDEF; track(q);
    for (int i = 0; i < NPEND; i++) begin
      q = '0; q.action = ACT_RELEASE; q.slot = 3'(i); track(q);
    end

    for (int phase = 0; phase < 3; phase++) begin
      send_idle_pct = (phase == 0) ? 31 : (phase == 1) ? 81 : 0;
      recv_idle_pct = (phase == 0) ? 81 : (phase == 1) ? 31 : 0;
      for (int n = 0; n < 138; n++) begin
        q = ($urandom_range(9) == 0) ? noise_item() : shaped_item();
        track(q);
      end
    end
    in_valid <= 0;

    while (sb.pending_results.size() > 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (sb.errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
